### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes, reset values, status type and the signed
// 32-bit saturation function of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int OPW      = DATA_W + 1;
   localparam int LIMIT_W  = 31;
   localparam int SAT_W    = 2 * DATA_W + 2 - FRAC_W;
   localparam int DIV_STEPS = DATA_W + FRAC_W;

   localparam int MUL_DIGIT_W_DEF = 4;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDUP_LIM  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_LIM   = 3'd5;

   localparam logic signed [DATA_W-1:0] GAIN_P_RST = 32'sd65536;
   localparam logic signed [DATA_W-1:0] GAIN_I_RST = 32'sd6554;
   localparam logic signed [DATA_W-1:0] GAIN_D_RST = 32'sd655;
   localparam logic signed [DATA_W-1:0] TARGET_RST = 32'sd0;
   localparam logic [LIMIT_W-1:0] WINDUP_LIM_RST = 31'd6553600;
   localparam logic [LIMIT_W-1:0] DRIVE_LIM_RST  = 31'd6553600;

   localparam logic ACT_STEP  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[SAT_W-1:DATA_W-1];
      all_zero = ~|v[SAT_W-1:DATA_W-1];
      if (all_one || all_zero) begin
         return v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         return S32_MIN;
      end else begin
         return S32_MAX;
      end
   endfunction

endpackage

### rtl/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Digit-serial signed multiplier: the second operand is consumed one digit
// per cycle from the low end, the partial sum shifts right into a low word.
// Gives the product shifted right by the fraction width (floor).
// ----------------------------------------------------------------------------
module pidc_mul #(
   parameter int DIGIT_W = pidc_pkg::MUL_DIGIT_W_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [pidc_pkg::OPW-1:0]       a,
   input  logic signed [pidc_pkg::OPW-1:0]       b,
   output pidc_pkg::unit_stat_type               stat,
   output logic signed [pidc_pkg::SAT_W-1:0]     prod_q
);

   localparam int DIGITS = (pidc_pkg::OPW + DIGIT_W - 1) / DIGIT_W;
   localparam int LO_W   = DIGITS * DIGIT_W;
   localparam int HI_W   = pidc_pkg::OPW + DIGIT_W + 1;
   localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int PROD_W = HI_W + LO_W;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);

   logic signed [pidc_pkg::OPW-1:0] a_ff, a_in;
   logic signed [LO_W-1:0]          b_ff, b_in;
   logic signed [HI_W-1:0]          hi_ff, hi_in;
   logic [LO_W-1:0]                 lo_ff, lo_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic signed [DIGIT_W:0]         dig;
   logic signed [HI_W-1:0]          pp;
   logic signed [HI_W-1:0]          tsum;
   logic [PROD_W-1:0]               prod;

   assign dig  = {((cnt_ff == LAST) ? b_ff[DIGIT_W-1] : 1'b0), b_ff[DIGIT_W-1:0]};
   assign pp   = a_ff * dig;
   assign tsum = hi_ff + pp;
   assign prod = {hi_ff, lo_ff};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = LO_W'(b);
         hi_in   = '0;
         lo_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = tsum >>> DIGIT_W;
         lo_in  = {tsum[DIGIT_W-1:0], lo_ff[LO_W-1:DIGIT_W]};
         b_in   = b_ff >>> DIGIT_W;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod_q    = prod[pidc_pkg::SAT_W+pidc_pkg::FRAC_W-1:pidc_pkg::FRAC_W];

endmodule

### rtl/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Bit-serial restoring divider for the derivative: (num * 2^16) / den,
// truncated toward zero and saturated to signed 32 bits. One quotient bit
// per cycle, then a final step to sign and saturate.
// ----------------------------------------------------------------------------
module pidc_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [pidc_pkg::OPW-1:0]       num,
   input  logic [pidc_pkg::DATA_W-1:0]           den,
   output pidc_pkg::unit_stat_type               stat,
   output logic signed [pidc_pkg::DATA_W-1:0]    quot
);

   localparam int DW    = pidc_pkg::DATA_W;
   localparam int QW    = pidc_pkg::DIV_STEPS;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW);

   logic                   neg_ff, neg_in;
   logic [DW-1:0]          den_ff, den_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [QW-1:0]          dvd_ff, dvd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic signed [DW-1:0]   quot_ff, quot_in;

   logic [pidc_pkg::OPW-1:0] mag;
   logic [DW:0]              trial;
   logic [DW:0]              tdiff;
   logic                     qbit;
   logic [DW-1:0]            qneg;

   assign mag   = num[pidc_pkg::OPW-1] ? -num : num;
   assign trial = {rem_ff, dvd_ff[QW-1]};
   assign tdiff = trial - {1'b0, den_ff};
   assign qbit  = ~tdiff[DW];
   assign qneg  = -dvd_ff[DW-1:0];

   always_comb begin
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      quot_in = quot_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = num[pidc_pkg::OPW-1];
         den_in  = den;
         rem_in  = '0;
         dvd_in  = {mag[DW-1:0], {pidc_pkg::FRAC_W{1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               if (|dvd_ff[QW-1:DW-1]) begin
                  quot_in = pidc_pkg::S32_MAX;
               end else begin
                  quot_in = dvd_ff[DW-1:0];
               end
            end else begin
               if ((|dvd_ff[QW-1:DW]) || (dvd_ff[DW-1] && (|dvd_ff[DW-2:0]))) begin
                  quot_in = pidc_pkg::S32_MIN;
               end else begin
                  quot_in = qneg;
               end
            end
         end else begin
            rem_in = qbit ? tdiff[DW-1:0] : trial[DW-1:0];
            dvd_in = {dvd_ff[QW-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

### rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Signed Q16.16 PID step with integral windup clamp and drive clamp.
// In a step item the derivative quotient comes from a 48-step bit-serial
// divider (one bit per cycle plus a final saturation step), and the
// derivative product follows it on the shared digit-serial multiplier,
// which works through ceil(33 / MUL_DIGIT_W) digits per product (9 at the
// default). The error times time_step product and the two P and I products
// run on that multiplier while the divider works. A zero time step skips
// the divider. A clear item's all-zero result is registered and then moved
// into the output register from ST_DONE once that register is free. One
// item is in work at a time; the next is taken while the previous result
// waits in the output register.
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
   parameter int MUL_DIGIT_W = pidc_pkg::MUL_DIGIT_W_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,  // measurement, time_step
   input  logic [0:0]                           req_tuser,  // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [63:0]                          rsp_tdata,  // drive, p_plus_i
   output logic [0:0]                           rsp_tuser,  // drive_saturated
   input  logic                                 csr_we,
   input  logic [pidc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [pidc_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int DW  = pidc_pkg::DATA_W;
   localparam int OW  = pidc_pkg::OPW;
   localparam int SW  = pidc_pkg::SAT_W;
   localparam int LW  = pidc_pkg::LIMIT_W;
   localparam int SUM_W = DW + 2;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_LOAD      = 4'd1;
   localparam logic [3:0] ST_WAIT_I    = 4'd2;
   localparam logic [3:0] ST_LAUNCH_P  = 4'd3;
   localparam logic [3:0] ST_WAIT_P    = 4'd4;
   localparam logic [3:0] ST_LAUNCH_II = 4'd5;
   localparam logic [3:0] ST_WAIT_II   = 4'd6;
   localparam logic [3:0] ST_LAUNCH_D  = 4'd7;
   localparam logic [3:0] ST_WAIT_D    = 4'd8;
   localparam logic [3:0] ST_FINISH    = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]             state_ff, state_in;

   logic signed [DW-1:0]   gain_p_ff, gain_p_in;
   logic signed [DW-1:0]   gain_i_ff, gain_i_in;
   logic signed [DW-1:0]   gain_d_ff, gain_d_in;
   logic signed [DW-1:0]   target_ff, target_in;
   logic [LW-1:0]          windup_ff, windup_in;
   logic [LW-1:0]          drv_lim_ff, drv_lim_in;

   logic signed [DW-1:0]   integ_ff, integ_in;
   logic signed [DW-1:0]   last_err_ff, last_err_in;
   logic signed [DW-1:0]   err_ff, err_in;
   logic [DW-1:0]          dt_ff, dt_in;
   logic signed [DW-1:0]   d_ff, d_in;
   logic                   d_valid_ff, d_valid_in;
   logic signed [DW-1:0]   tp_ff, tp_in;
   logic signed [DW-1:0]   ti_ff, ti_in;
   logic signed [DW-1:0]   td_ff, td_in;
   logic signed [DW-1:0]   res_drive_ff, res_drive_in;
   logic signed [DW-1:0]   res_pi_ff, res_pi_in;
   logic                   res_sat_ff, res_sat_in;
   logic signed [DW-1:0]   rsp_drive_ff, rsp_drive_in;
   logic signed [DW-1:0]   rsp_pi_ff, rsp_pi_in;
   logic                   rsp_sat_ff, rsp_sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_fire;
   logic signed [DW-1:0]   req_meas;
   logic [DW-1:0]          req_dt;
   logic signed [DW-1:0]   err_new;
   logic                   dt_zero;

   logic                   mul_start;
   logic signed [OW-1:0]   mul_a;
   logic signed [OW-1:0]   mul_b;
   pidc_pkg::unit_stat_type mul_stat;
   logic signed [SW-1:0]   mul_q;

   logic                   div_start;
   logic signed [OW-1:0]   div_num;
   pidc_pkg::unit_stat_type div_stat;
   logic signed [DW-1:0]   div_q;

   logic signed [SW-1:0]   integ_acc;
   logic signed [SW-1:0]   win_lim;
   logic signed [SW-1:0]   win_neg;
   logic signed [SUM_W-1:0] drive_sum;
   logic signed [SUM_W-1:0] drv_lim;
   logic signed [SUM_W-1:0] drv_neg;

   logic signed [OW-1:0]   integ_chk;
   logic signed [OW-1:0]   win_chk;
   logic signed [OW-1:0]   drive_chk;
   logic signed [OW-1:0]   drv_chk;

   assign req_fire = req_tvalid && req_tready;
   assign req_meas = req_tdata[DW-1:0];
   assign req_dt   = req_tdata[2*DW-1:DW];
   assign err_new  = pidc_pkg::sat32(SW'(OW'(target_ff) - OW'(req_meas)));
   assign dt_zero  = (dt_ff == '0);
   assign div_num  = OW'(err_ff) - OW'(last_err_ff);

   assign integ_acc = SW'(integ_ff) + mul_q;
   assign win_lim   = $signed({{(SW-LW){1'b0}}, windup_ff});
   assign win_neg   = -win_lim;
   assign drive_sum = SUM_W'(tp_ff) + SUM_W'(ti_ff) + SUM_W'(td_ff);
   assign drv_lim   = $signed({{(SUM_W-LW){1'b0}}, drv_lim_ff});
   assign drv_neg   = -drv_lim;

   pidc_mul #(
      .DIGIT_W (MUL_DIGIT_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .stat   (mul_stat),
      .prod_q (mul_q)
   );

   pidc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dt_ff),
      .stat  (div_stat),
      .quot  (div_q)
   );

   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      target_in    = target_ff;
      windup_in    = windup_ff;
      drv_lim_in   = drv_lim_ff;
      state_in     = state_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      d_in         = d_ff;
      d_valid_in   = d_valid_ff;
      tp_in        = tp_ff;
      ti_in        = ti_ff;
      td_in        = td_ff;
      res_drive_in = res_drive_ff;
      res_pi_in    = res_pi_ff;
      res_sat_in   = res_sat_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_pi_in    = rsp_pi_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_start    = 1'b0;
      mul_a        = OW'(err_ff);
      mul_b        = '0;
      div_start    = 1'b0;

      if (csr_we) begin
         unique case (csr_addr)
            pidc_pkg::CSR_GAIN_P:     gain_p_in  = csr_wdata;
            pidc_pkg::CSR_GAIN_I:     gain_i_in  = csr_wdata;
            pidc_pkg::CSR_GAIN_D:     gain_d_in  = csr_wdata;
            pidc_pkg::CSR_TARGET:     target_in  = csr_wdata;
            pidc_pkg::CSR_WINDUP_LIM: windup_in  = csr_wdata[LW-1:0];
            pidc_pkg::CSR_DRIVE_LIM:  drv_lim_in = csr_wdata[LW-1:0];
            default: ;
         endcase
      end

      // drop the result once its transfer completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // hold the derivative quotient
      if (div_stat.done) begin
         d_in       = div_q;
         d_valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == pidc_pkg::ACT_CLEAR) begin
                  integ_in     = '0;
                  last_err_in  = '0;
                  res_drive_in = '0;
                  res_pi_in    = '0;
                  res_sat_in   = 1'b0;
                  state_in     = ST_DONE;
               end else begin
                  err_in   = err_new;
                  dt_in    = req_dt;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            mul_start   = 1'b1;
            mul_a       = OW'(err_ff);
            mul_b       = {1'b0, dt_ff};
            div_start   = !dt_zero;
            last_err_in = err_ff;
            d_in        = '0;
            d_valid_in  = 1'b0;
            state_in    = ST_WAIT_I;
         end
         ST_WAIT_I: begin
            if (mul_stat.done) begin
               if (integ_acc > win_lim) begin
                  integ_in = win_lim[DW-1:0];
               end else if (integ_acc < win_neg) begin
                  integ_in = win_neg[DW-1:0];
               end else begin
                  integ_in = integ_acc[DW-1:0];
               end
               state_in = ST_LAUNCH_P;
            end
         end
         ST_LAUNCH_P: begin
            mul_start = 1'b1;
            mul_a     = OW'(gain_p_ff);
            mul_b     = OW'(err_ff);
            state_in  = ST_WAIT_P;
         end
         ST_WAIT_P: begin
            if (mul_stat.done) begin
               tp_in    = pidc_pkg::sat32(mul_q);
               state_in = ST_LAUNCH_II;
            end
         end
         ST_LAUNCH_II: begin
            mul_start = 1'b1;
            mul_a     = OW'(gain_i_ff);
            mul_b     = OW'(integ_ff);
            state_in  = ST_WAIT_II;
         end
         ST_WAIT_II: begin
            if (mul_stat.done) begin
               ti_in    = pidc_pkg::sat32(mul_q);
               state_in = ST_LAUNCH_D;
            end
         end
         ST_LAUNCH_D: begin
            if (dt_zero || d_valid_ff) begin
               mul_start = 1'b1;
               mul_a     = OW'(gain_d_ff);
               mul_b     = OW'(d_ff);
               state_in  = ST_WAIT_D;
            end
         end
         ST_WAIT_D: begin
            if (mul_stat.done) begin
               td_in    = pidc_pkg::sat32(mul_q);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (drive_sum > drv_lim) begin
               res_drive_in = drv_lim[DW-1:0];
               res_sat_in   = 1'b1;
            end else if (drive_sum < drv_neg) begin
               res_drive_in = drv_neg[DW-1:0];
               res_sat_in   = 1'b1;
            end else begin
               res_drive_in = drive_sum[DW-1:0];
               res_sat_in   = 1'b0;
            end
            res_pi_in = pidc_pkg::sat32(SW'(OW'(tp_ff) + OW'(ti_ff)));
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_drive_in = res_drive_ff;
               rsp_pi_in    = res_pi_ff;
               rsp_sat_in   = res_sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_p_ff    <= pidc_pkg::GAIN_P_RST;
         gain_i_ff    <= pidc_pkg::GAIN_I_RST;
         gain_d_ff    <= pidc_pkg::GAIN_D_RST;
         target_ff    <= pidc_pkg::TARGET_RST;
         windup_ff    <= pidc_pkg::WINDUP_LIM_RST;
         drv_lim_ff   <= pidc_pkg::DRIVE_LIM_RST;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         target_ff    <= target_in;
         windup_ff    <= windup_in;
         drv_lim_ff   <= drv_lim_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      d_ff         <= d_in;
      tp_ff        <= tp_in;
      ti_ff        <= ti_in;
      td_ff        <= td_in;
      res_drive_ff <= res_drive_in;
      res_pi_ff    <= res_pi_in;
      res_sat_ff   <= res_sat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_pi_ff    <= rsp_pi_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pi_ff, rsp_drive_ff};
   assign rsp_tuser  = rsp_sat_ff;

   assign integ_chk = OW'(integ_ff);
   assign win_chk   = $signed({2'b00, windup_ff});
   assign drive_chk = OW'(res_drive_ff);
   assign drv_chk   = $signed({2'b00, drv_lim_ff});

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser[0] == pidc_pkg::ACT_CLEAR)) |=>
      (state_ff == ST_DONE && integ_ff == '0 && last_err_ff == '0))
      else $error("clear did not zero the controller state");

   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT_I && mul_stat.done) |=>
      (integ_chk <= $past(win_chk) && integ_chk >= -$past(win_chk)))
      else $error("integral outside windup limit");

   a_drive_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=>
      (drive_chk <= $past(drv_chk) && drive_chk >= -$past(drv_chk)))
      else $error("drive outside drive limit");

   a_div_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT_D) |-> !div_stat.busy)
      else $error("derivative product started before the quotient settled");

endmodule
